// ===== hdl/boc_pkg.sv =====
// ----------------------------------------------------------------------------
// boc_pkg
// Shared types, widths and codes for the BOC code autocorrelation unit.
// ----------------------------------------------------------------------------
package boc_pkg;

  // fixed-point format of delay and correlation
  localparam int FRAC_BITS = 16;
  localparam int ONE       = 65536;

  // field widths
  localparam int DELAY_W  = 24;
  localparam int CORR_W   = 18;
  localparam int MULT_W   = 7;
  localparam int POWER_W  = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // datapath widths, sized for the largest supported multiple
  localparam int N_W    = 28;
  localparam int MA_W   = 28;
  localparam int MB_W   = 18;
  localparam int MP_W   = MA_W + MB_W;
  localparam int DEN_W  = 28;
  localparam int DIV_NW = 46;
  localparam int DIV_DW = 28;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMARY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECONDARY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWER     = 3'd4;

  typedef enum logic [1:0] {
    MODEL_BPSK,
    MODEL_TMBOC,
    MODEL_COMPOSITE,
    MODEL_RESERVED
  } model_t;

  typedef enum logic [1:0] {
    PHASE_POS,
    PHASE_NEG,
    PHASE_POS_J,
    PHASE_NEG_J
  } phase_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hdl/boc_div.sv =====
// ----------------------------------------------------------------------------
// boc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module boc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  boc_pkg::div_req_t req,
  output boc_pkg::div_rsp_t rsp
);

  logic                       busy_r;
  logic                       done_r;
  logic [boc_pkg::DIV_CW-1:0] cnt_r;
  logic [boc_pkg::DIV_DW-1:0] rem_r;
  logic [boc_pkg::DIV_DW-1:0] den_r;
  logic [boc_pkg::DIV_NW-1:0] quo_r;

  logic [boc_pkg::DIV_DW:0]   trial;
  logic                       fits;

  // shift in next dividend bit and trial subtract
  assign trial = {rem_r, quo_r[boc_pkg::DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= boc_pkg::DIV_CW'(boc_pkg::DIV_NW);
      rem_r  <= '0;
      den_r  <= req.den;
      quo_r  <= req.num;
    end else if (busy_r) begin
      rem_r <= fits ? boc_pkg::DIV_DW'(trial - {1'b0, den_r}) : trial[boc_pkg::DIV_DW-1:0];
      quo_r <= {quo_r[boc_pkg::DIV_NW-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == boc_pkg::DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== hdl/boc_code_autocorrelation_unit.sv =====
// ----------------------------------------------------------------------------
// boc_code_autocorrelation_unit
// Ideal complex code autocorrelation for BPSK, TMBOC and composite BOC.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------
//  input   | in_delay_chips                          | in_valid/in_ready
//  result  | out_corr_re, out_corr_im, out_status    | out_valid/out_ready
//  config  | cfg_index, cfg_data                     | cfg_we
//
// BPSK items and items with a reserved model or a bad multiple go
// straight from idle to done. Composite items take 5 divisions, a
// 16-step square root, a code advance, a walk over 2*lcm segments
// and 11 steps on the shared multiplier; TMBOC runs the composite
// walk twice. The shared divider and the segment walk set the item time.
// Reset is synchronous; the block takes an item only in its idle state
// and holds a finished result in the output register until it is taken.
module boc_code_autocorrelation_unit #(
  parameter int MAX_MULTIPLE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [boc_pkg::DELAY_W-1:0] in_delay_chips,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [boc_pkg::CORR_W-1:0]  out_corr_re,
  output logic signed [boc_pkg::CORR_W-1:0]  out_corr_im,
  output logic                               out_status,
  input  logic                               cfg_we,
  input  logic [boc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [boc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LW = $clog2(MAX_MULTIPLE + 1);
  localparam int SW = LW + 1;
  localparam int AW = SW + 1;
  localparam int MW = boc_pkg::MULT_W;
  localparam int PW = boc_pkg::POWER_W;
  localparam int CW = boc_pkg::CORR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_GCD, S_LCM, S_PER_P, S_PER_S, S_SQV, S_SQRT, S_KPREP,
    S_ADV, S_ACC, S_NUM, S_DIVRE, S_DIVIM, S_RUNEND, S_MIX, S_DONE
  } state_t;

  // configuration registers
  boc_pkg::model_t model_r;
  logic [MW-1:0]   prim_r;
  logic [MW-1:0]   sec_r;
  boc_pkg::phase_t phase_r;
  logic [PW-1:0]   power_r;

  state_t state_r;

  // item and run registers
  logic                        neg_r;
  logic [boc_pkg::DELAY_W-1:0] dmag_r;
  logic [PW-1:0]               p_r;
  logic [PW-1:0]               q_r;
  logic                        run_r;
  logic [MW-1:0]               np_r, ns_r, ga_r, gb_r;
  logic [PW-1:0]               ca_r, cb_r;
  boc_pkg::phase_t             ph_r;
  logic [LW-1:0]               lcm_r, per_p_r, per_s_r;
  logic [32:0]                 v_r;
  logic [15:0]                 x_r;
  logic [3:0]                  sb_r;
  logic [SW-1:0]               k_r, adv_r, j_r;
  logic [15:0]                 r_r;
  logic [LW-1:0]               gcnt_r [6];
  logic [5:0]                  gsgn_r;
  logic signed [AW-1:0]        cpp_r [2];
  logic signed [AW-1:0]        css_r [2];
  logic signed [AW-1:0]        cps_r [2];
  logic signed [AW-1:0]        csp_r [2];
  logic signed [AW-1:0]        sps_r;
  logic [3:0]                  step_r;
  logic signed [boc_pkg::N_W-1:0]   nre_r [2];
  logic signed [boc_pkg::N_W-1:0]   nim_r [2];
  logic signed [boc_pkg::MP_W-1:0]  numre_r, numim_r;
  logic signed [boc_pkg::DEN_W-1:0] den_r;
  logic                        issued_r;
  logic signed [CW-1:0]        r1_r, rre_r, rim_r;
  logic signed [CW-1:0]        res_re_r, res_im_r;
  logic                        res_st_r;

  // output register
  logic                 out_valid_r;
  logic signed [CW-1:0] out_re_r, out_im_r;
  logic                 out_st_r;

  // combinational helpers
  logic [SW-1:0]                    segs;
  logic [15:0]                      cand;
  logic signed [boc_pkg::MA_W-1:0]  ma;
  logic signed [boc_pkg::MB_W-1:0]  mb;
  logic signed [boc_pkg::MP_W-1:0]  mp;
  logic signed [AW:0]               xs0, xs1;
  logic [LW-1:0]                    gcnt_nxt [6];
  logic [5:0]                       gsgn_nxt;
  logic [5:0]                       gen_en;
  logic signed [boc_pkg::DEN_W-1:0] den_nxt;
  logic [boc_pkg::MP_W-1:0]         mag;
  logic [boc_pkg::MP_W-1:0]         num_abs;
  logic                             num_neg;
  logic signed [CW-1:0]             qsat;
  logic [boc_pkg::DIV_NW-1:0]       mix_q;
  logic signed [CW-1:0]             mix_res;
  logic                             inA, inB;
  logic                             div_state;
  logic [13:0]                      lcm_full;
  boc_pkg::div_req_t                div_req;
  boc_pkg::div_rsp_t                div_rsp;
  logic                             n1_ok, n2_ok;
  logic [boc_pkg::DELAY_W-1:0]      in_mag;
  logic [PW-1:0]                    in_p;

  assign segs = {lcm_r, 1'b0};
  assign cand = x_r | (16'd1 << sb_r);

  // phase-dependent cross terms
  assign xs0 = (ph_r == boc_pkg::PHASE_POS || ph_r == boc_pkg::PHASE_NEG)
             ? ((AW+1)'(cps_r[0]) + (AW+1)'(csp_r[0]))
             : ((AW+1)'(csp_r[0]) - (AW+1)'(cps_r[0]));
  assign xs1 = (ph_r == boc_pkg::PHASE_POS || ph_r == boc_pkg::PHASE_NEG)
             ? ((AW+1)'(cps_r[1]) + (AW+1)'(csp_r[1]))
             : ((AW+1)'(csp_r[1]) - (AW+1)'(cps_r[1]));

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_SQV: begin
        ma = boc_pkg::MA_W'({1'b0, cb_r});
        mb = boc_pkg::MB_W'({1'b0, ca_r});
      end
      S_SQRT: begin
        ma = boc_pkg::MA_W'({1'b0, cand});
        mb = boc_pkg::MB_W'({1'b0, cand});
      end
      S_KPREP: begin
        ma = boc_pkg::MA_W'({1'b0, dmag_r[15:0]});
        mb = boc_pkg::MB_W'({1'b0, segs});
      end
      S_NUM: begin
        case (step_r)
          4'd0: begin ma = boc_pkg::MA_W'(cpp_r[0]); mb = boc_pkg::MB_W'({1'b0, ca_r}); end
          4'd1: begin ma = boc_pkg::MA_W'(css_r[0]); mb = boc_pkg::MB_W'({1'b0, cb_r}); end
          4'd2: begin ma = boc_pkg::MA_W'(xs0); mb = boc_pkg::MB_W'({1'b0, x_r}); end
          4'd3: begin ma = boc_pkg::MA_W'(cpp_r[1]); mb = boc_pkg::MB_W'({1'b0, ca_r}); end
          4'd4: begin ma = boc_pkg::MA_W'(css_r[1]); mb = boc_pkg::MB_W'({1'b0, cb_r}); end
          4'd5: begin ma = boc_pkg::MA_W'(xs1); mb = boc_pkg::MB_W'({1'b0, x_r}); end
          4'd6: begin
            ma = boc_pkg::MA_W'(nre_r[0]);
            mb = boc_pkg::MB_W'(boc_pkg::ONE) - boc_pkg::MB_W'({1'b0, r_r});
          end
          4'd7: begin ma = boc_pkg::MA_W'(nre_r[1]); mb = boc_pkg::MB_W'({1'b0, r_r}); end
          4'd8: begin
            ma = boc_pkg::MA_W'(nim_r[0]);
            mb = boc_pkg::MB_W'(boc_pkg::ONE) - boc_pkg::MB_W'({1'b0, r_r});
          end
          4'd9: begin ma = boc_pkg::MA_W'(nim_r[1]); mb = boc_pkg::MB_W'({1'b0, r_r}); end
          default: begin ma = boc_pkg::MA_W'(sps_r); mb = boc_pkg::MB_W'({1'b0, x_r}); end
        endcase
      end
      S_MIX: begin
        if (step_r == 4'd0) begin
          ma = boc_pkg::MA_W'(r1_r);
          mb = boc_pkg::MB_W'({1'b0, q_r});
        end else begin
          ma = boc_pkg::MA_W'(rre_r);
          mb = boc_pkg::MB_W'({1'b0, p_r});
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mp = ma * mb;

  // subcarrier generators: 0/1 lag, 2/3 lead at k, 4/5 lead at k+1
  always_comb begin
    for (int g = 0; g < 6; g++) begin
      logic [LW-1:0] per;
      logic          wrap;
      per         = g[0] ? per_s_r : per_p_r;
      wrap        = gcnt_r[g] == LW'(per - 1'b1);
      gcnt_nxt[g] = wrap ? '0 : LW'(gcnt_r[g] + 1'b1);
      gsgn_nxt[g] = gsgn_r[g] ^ wrap;
    end
  end

  always_comb begin
    gen_en = 6'b000000;
    case (state_r)
      S_ADV:   gen_en = (adv_r != k_r) ? 6'b111100 : 6'b110000;
      S_ACC:   gen_en = 6'b111111;
      default: gen_en = 6'b000000;
    endcase
  end

  // overlap ranges of the two lags
  assign inA = ({1'b0, j_r} + {1'b0, k_r}) < {1'b0, segs};
  assign inB = ({1'b0, j_r} + {1'b0, k_r} + (SW+1)'(1)) < {1'b0, segs};

  // energy normalizer
  always_comb begin
    den_nxt = boc_pkg::DEN_W'({segs, 16'h0000});
    case (ph_r)
      boc_pkg::PHASE_POS: den_nxt = den_nxt + (boc_pkg::DEN_W'(mp) <<< 1);
      boc_pkg::PHASE_NEG: den_nxt = den_nxt - (boc_pkg::DEN_W'(mp) <<< 1);
      default:            den_nxt = den_nxt;
    endcase
  end

  // divider hookup, rounding offset added to the numerator magnitude
  assign num_neg = (state_r == S_DIVIM) ? numim_r[boc_pkg::MP_W-1] : numre_r[boc_pkg::MP_W-1];
  assign num_abs = (state_r == S_DIVIM)
                 ? (numim_r[boc_pkg::MP_W-1] ? boc_pkg::MP_W'(-numim_r) : numim_r)
                 : (numre_r[boc_pkg::MP_W-1] ? boc_pkg::MP_W'(-numre_r) : numre_r);
  assign div_state = state_r == S_LCM || state_r == S_PER_P || state_r == S_PER_S ||
                     state_r == S_DIVRE || state_r == S_DIVIM;

  always_comb begin
    div_req.start = div_state && !issued_r;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state_r)
      S_LCM: begin
        div_req.num = boc_pkg::DIV_NW'(np_r) * boc_pkg::DIV_NW'(ns_r);
        div_req.den = boc_pkg::DIV_DW'(ga_r);
      end
      S_PER_P: begin
        div_req.num = boc_pkg::DIV_NW'(lcm_r);
        div_req.den = boc_pkg::DIV_DW'(np_r);
      end
      S_PER_S: begin
        div_req.num = boc_pkg::DIV_NW'(lcm_r);
        div_req.den = boc_pkg::DIV_DW'(ns_r);
      end
      S_DIVRE, S_DIVIM: begin
        div_req.num = boc_pkg::DIV_NW'(num_abs) + boc_pkg::DIV_NW'(den_r[boc_pkg::DEN_W-1:1]);
        div_req.den = boc_pkg::DIV_DW'(den_r);
      end
      default: begin
        div_req.num = '0;
        div_req.den = '0;
      end
    endcase
  end

  boc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // saturated, signed quotient
  always_comb begin
    logic [CW-1:0] qm;
    qm   = (div_rsp.quo > boc_pkg::DIV_NW'(boc_pkg::ONE)) ? CW'(boc_pkg::ONE)
                                                          : CW'(div_rsp.quo);
    qsat = num_neg ? -$signed(qm) : $signed(qm);
  end

  assign lcm_full = div_rsp.quo[13:0];

  // weighted sum rounding for the time-multiplexed model
  always_comb begin
    logic [CW-1:0] qm;
    mag     = numre_r[boc_pkg::MP_W-1] ? boc_pkg::MP_W'(-numre_r) : numre_r;
    mix_q   = (boc_pkg::DIV_NW'(mag) + boc_pkg::DIV_NW'(boc_pkg::ONE / 2)) >> boc_pkg::FRAC_BITS;
    qm      = (mix_q > boc_pkg::DIV_NW'(boc_pkg::ONE)) ? CW'(boc_pkg::ONE) : CW'(mix_q);
    mix_res = numre_r[boc_pkg::MP_W-1] ? -$signed(qm) : $signed(qm);
  end

  // input decode
  assign in_mag = in_delay_chips[boc_pkg::DELAY_W-1] ? boc_pkg::DELAY_W'(-in_delay_chips)
                                                     : in_delay_chips;
  assign in_p   = (power_r > PW'(boc_pkg::ONE)) ? PW'(boc_pkg::ONE) : power_r;
  assign n1_ok  = prim_r != '0 && {2'b00, prim_r} <= 9'(MAX_MULTIPLE);
  assign n2_ok  = sec_r != '0 && {2'b00, sec_r} <= 9'(MAX_MULTIPLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= boc_pkg::MODEL_BPSK;
      prim_r  <= MW'(1);
      sec_r   <= MW'(6);
      phase_r <= boc_pkg::PHASE_POS;
      power_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        boc_pkg::REG_MODEL:     model_r <= boc_pkg::model_t'(cfg_data[1:0]);
        boc_pkg::REG_PRIMARY:   prim_r  <= cfg_data[MW-1:0];
        boc_pkg::REG_SECONDARY: sec_r   <= cfg_data[MW-1:0];
        boc_pkg::REG_PHASE:     phase_r <= boc_pkg::phase_t'(cfg_data[1:0]);
        boc_pkg::REG_POWER:     power_r <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      run_r       <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      for (int g = 0; g < 6; g++) begin
        if (gen_en[g]) begin
          gcnt_r[g] <= gcnt_nxt[g];
          gsgn_r[g] <= gsgn_nxt[g];
        end
      end

      if (div_rsp.done)       issued_r <= 1'b0;
      else if (div_req.start) issued_r <= 1'b1;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            neg_r    <= in_delay_chips[boc_pkg::DELAY_W-1];
            dmag_r   <= in_mag;
            p_r      <= in_p;
            q_r      <= PW'(boc_pkg::ONE - int'(in_p));
            run_r    <= 1'b0;
            res_im_r <= '0;
            res_st_r <= (model_r == boc_pkg::MODEL_RESERVED) ||
                        (model_r != boc_pkg::MODEL_BPSK && !(n1_ok && n2_ok));
            res_re_r <= (model_r == boc_pkg::MODEL_BPSK &&
                         in_mag < boc_pkg::DELAY_W'(boc_pkg::ONE))
                      ? CW'(boc_pkg::ONE) - CW'(in_mag) : '0;
            if (model_r == boc_pkg::MODEL_RESERVED) begin
              state_r  <= S_DONE;
            end else if (model_r != boc_pkg::MODEL_BPSK && !(n1_ok && n2_ok)) begin
              state_r  <= S_DONE;
            end else if (model_r == boc_pkg::MODEL_BPSK) begin
              state_r <= S_DONE;
            end else if (model_r == boc_pkg::MODEL_TMBOC) begin
              np_r    <= prim_r;
              ns_r    <= prim_r;
              ga_r    <= prim_r;
              gb_r    <= prim_r;
              ca_r    <= PW'(boc_pkg::ONE);
              cb_r    <= '0;
              ph_r    <= boc_pkg::PHASE_POS;
              state_r <= S_GCD;
            end else begin
              np_r    <= prim_r;
              ns_r    <= sec_r;
              ga_r    <= prim_r;
              gb_r    <= sec_r;
              ca_r    <= PW'(boc_pkg::ONE - int'(in_p));
              cb_r    <= in_p;
              ph_r    <= phase_r;
              state_r <= S_GCD;
            end
          end
        end

        // subtractive gcd
        S_GCD: begin
          if (ga_r == gb_r) state_r <= S_LCM;
          else if (ga_r > gb_r) ga_r <= ga_r - gb_r;
          else gb_r <= gb_r - ga_r;
        end

        S_LCM: begin
          if (div_rsp.done) begin
            if (model_r == boc_pkg::MODEL_COMPOSITE && lcm_full > 14'(MAX_MULTIPLE)) begin
              res_st_r <= 1'b1;
              state_r  <= S_DONE;
            end else if (dmag_r >= boc_pkg::DELAY_W'(boc_pkg::ONE)) begin
              state_r <= S_DONE;
            end else begin
              lcm_r   <= LW'(lcm_full);
              state_r <= S_PER_P;
            end
          end
        end

        S_PER_P: begin
          if (div_rsp.done) begin
            per_p_r <= LW'(div_rsp.quo);
            state_r <= S_PER_S;
          end
        end

        S_PER_S: begin
          if (div_rsp.done) begin
            per_s_r <= LW'(div_rsp.quo);
            state_r <= S_SQV;
          end
        end

        // cross weight is floor(sqrt(p*(1-p)))
        S_SQV: begin
          v_r     <= mp[32:0];
          x_r     <= '0;
          sb_r    <= 4'd15;
          state_r <= S_SQRT;
        end

        S_SQRT: begin
          if (mp[32:0] <= v_r) x_r <= cand;
          if (sb_r == 4'd0) state_r <= S_KPREP;
          else sb_r <= sb_r - 1'b1;
        end

        // split delay into whole segments and remainder
        S_KPREP: begin
          k_r   <= mp[16+SW-1:16];
          r_r   <= mp[15:0];
          adv_r <= '0;
          for (int g = 0; g < 6; g++) gcnt_r[g] <= '0;
          gsgn_r <= '0;
          for (int t = 0; t < 2; t++) begin
            cpp_r[t] <= '0;
            css_r[t] <= '0;
            cps_r[t] <= '0;
            csp_r[t] <= '0;
          end
          sps_r   <= '0;
          state_r <= S_ADV;
        end

        // move lead generators forward by the lag
        S_ADV: begin
          if (adv_r != k_r) begin
            adv_r <= adv_r + 1'b1;
          end else begin
            j_r     <= '0;
            state_r <= S_ACC;
          end
        end

        // segment walk accumulating all cross sums
        S_ACC: begin
          if (inA) begin
            cpp_r[0] <= (gsgn_r[2] == gsgn_r[0]) ? cpp_r[0] + 1'b1 : cpp_r[0] - 1'b1;
            css_r[0] <= (gsgn_r[3] == gsgn_r[1]) ? css_r[0] + 1'b1 : css_r[0] - 1'b1;
            cps_r[0] <= (gsgn_r[2] == gsgn_r[1]) ? cps_r[0] + 1'b1 : cps_r[0] - 1'b1;
            csp_r[0] <= (gsgn_r[3] == gsgn_r[0]) ? csp_r[0] + 1'b1 : csp_r[0] - 1'b1;
          end
          if (inB) begin
            cpp_r[1] <= (gsgn_r[4] == gsgn_r[0]) ? cpp_r[1] + 1'b1 : cpp_r[1] - 1'b1;
            css_r[1] <= (gsgn_r[5] == gsgn_r[1]) ? css_r[1] + 1'b1 : css_r[1] - 1'b1;
            cps_r[1] <= (gsgn_r[4] == gsgn_r[1]) ? cps_r[1] + 1'b1 : cps_r[1] - 1'b1;
            csp_r[1] <= (gsgn_r[5] == gsgn_r[0]) ? csp_r[1] + 1'b1 : csp_r[1] - 1'b1;
          end
          sps_r <= (gsgn_r[0] == gsgn_r[1]) ? sps_r + 1'b1 : sps_r - 1'b1;
          j_r   <= j_r + 1'b1;
          if (j_r == SW'(segs - 1'b1)) begin
            step_r  <= '0;
            state_r <= S_NUM;
          end
        end

        // weighted lag sums, interpolation and energy
        S_NUM: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd0: begin nre_r[0] <= boc_pkg::N_W'(mp); nim_r[0] <= '0; end
            4'd1: nre_r[0] <= nre_r[0] + boc_pkg::N_W'(mp);
            4'd2: begin
              case (ph_r)
                boc_pkg::PHASE_POS:   nre_r[0] <= nre_r[0] + boc_pkg::N_W'(mp);
                boc_pkg::PHASE_NEG:   nre_r[0] <= nre_r[0] - boc_pkg::N_W'(mp);
                boc_pkg::PHASE_POS_J: nim_r[0] <= boc_pkg::N_W'(mp);
                default:              nim_r[0] <= -boc_pkg::N_W'(mp);
              endcase
            end
            4'd3: begin nre_r[1] <= boc_pkg::N_W'(mp); nim_r[1] <= '0; end
            4'd4: nre_r[1] <= nre_r[1] + boc_pkg::N_W'(mp);
            4'd5: begin
              case (ph_r)
                boc_pkg::PHASE_POS:   nre_r[1] <= nre_r[1] + boc_pkg::N_W'(mp);
                boc_pkg::PHASE_NEG:   nre_r[1] <= nre_r[1] - boc_pkg::N_W'(mp);
                boc_pkg::PHASE_POS_J: nim_r[1] <= boc_pkg::N_W'(mp);
                default:              nim_r[1] <= -boc_pkg::N_W'(mp);
              endcase
            end
            4'd6: numre_r <= mp;
            4'd7: numre_r <= numre_r + mp;
            4'd8: numim_r <= mp;
            4'd9: numim_r <= numim_r + mp;
            default: begin
              den_r <= den_nxt;
              if (den_nxt <= 0) begin
                rre_r   <= '0;
                rim_r   <= '0;
                state_r <= S_RUNEND;
              end else begin
                state_r <= S_DIVRE;
              end
            end
          endcase
        end

        S_DIVRE: begin
          if (div_rsp.done) begin
            rre_r   <= qsat;
            state_r <= S_DIVIM;
          end
        end

        S_DIVIM: begin
          if (div_rsp.done) begin
            rim_r   <= qsat;
            state_r <= S_RUNEND;
          end
        end

        S_RUNEND: begin
          if (model_r == boc_pkg::MODEL_TMBOC) begin
            if (!run_r) begin
              r1_r    <= rre_r;
              run_r   <= 1'b1;
              np_r    <= sec_r;
              ns_r    <= sec_r;
              ga_r    <= sec_r;
              gb_r    <= sec_r;
              state_r <= S_GCD;
            end else begin
              step_r  <= '0;
              state_r <= S_MIX;
            end
          end else begin
            res_re_r <= rre_r;
            res_im_r <= rim_r;
            state_r  <= S_DONE;
          end
        end

        // power-weighted sum of the two BOC terms
        S_MIX: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd0: numre_r <= mp;
            4'd1: numre_r <= numre_r + mp;
            default: begin
              res_re_r <= mix_res;
              state_r  <= S_DONE;
            end
          endcase
        end

        // hand the result to the output register, conjugate for negative delay
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_re_r    <= res_re_r;
            out_im_r    <= neg_r ? -res_im_r : res_im_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready    = state_r == S_IDLE;
  assign out_valid   = out_valid_r;
  assign out_corr_re = out_re_r;
  assign out_corr_im = out_im_r;
  assign out_status  = out_st_r;

endmodule
